// File: src/sbe_pkg.sv
// sbe_pkg: shared types, codes and constants of the sprite blit engine
// no dependencies; imported by sbe_seq and sprite_blit_engine_unit
package sbe_pkg;

    // item kinds carried on the input tuser
    typedef enum logic [1:0] {
        OP_PARAM     = 2'd0,
        OP_TICK      = 2'd1,
        OP_SPRITE_WR = 2'd2
    } t_opcode;

    // parameter register indexes
    typedef enum logic [2:0] {
        P_DX      = 3'd0,
        P_DY      = 3'd1,
        P_SX      = 3'd2,
        P_SY      = 3'd3,
        P_WIDTH   = 3'd4,
        P_HEIGHT  = 3'd5,
        P_TRIGGER = 3'd6,
        P_COLOR   = 3'd7
    } t_param_idx;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CARRY_FULL  = 3'd0,
        CFG_FILL_MODE   = 3'd1,
        CFG_COPY_ENABLE = 3'd2,
        CFG_WRITE_ZERO  = 3'd3,
        CFG_SPRITE_BANK = 3'd4,
        CFG_FRAME_PAGE  = 3'd5,
        CFG_CLIP_X      = 3'd6,
        CFG_CLIP_Y      = 3'd7
    } t_cfg_idx;

    localparam int PARAM_COUNT = 8;

    localparam logic [7:0] CNT_MASK = 8'h7F;
    localparam logic [7:0] MSB_MASK = 8'h80;
    localparam logic [7:0] HI_NIB   = 8'hF0;
    localparam logic [7:0] LO_NIB   = 8'h0F;

    // sequencer status after one item, handed to the fetch stage
    typedef struct packed {
        logic       tick;
        logic       run;
        logic       irq;
        logic [7:0] dest_x;
        logic [7:0] dest_y;
        logic [7:0] gx;
        logic [7:0] gy;
        logic [7:0] fill_color;
    } t_tick_info;

    // source counter step: full 8-bit increment or low nibble only
    function automatic logic [7:0] src_inc(input logic [7:0] v, input logic full);
        logic [7:0] inc;
        inc = v + 8'd1;
        return full ? inc : ((v & HI_NIB) | (inc & LO_NIB));
    endfunction

endpackage

// File: src/sprite_blit_engine_unit.sv
// sprite_blit_engine_unit: top level of the sprite blit engine
// depends on sbe_pkg, sbe_seq and sbe_ram
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser opcode, tdata param/sprite fields
// m_axis    out  m_axis_tvalid/m_axis_tready    tuser write_valid, tdata pixel/status
// cfg       in   i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
// one request per cycle sustained while m_axis_tready is high; stages: sequencer
// update and sprite ram read issue on intake, fetch stage for color and write
// gating, output register; the registered sprite ram read sets the depth; each
// stage stalls only when the stage after it is full and not drained
// synchronous active-low reset clears control and counters, not the sprite ram
module sprite_blit_engine_unit #(
    parameter int SPRITE_BANKS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [2:0]  i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // opcode
    input  logic [39:0] s_axis_tdata,   // param_index, param_value, sprite_addr, sprite_data
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic        m_axis_tuser,   // write_valid
    output logic [31:0] m_axis_tdata    // pixel_addr, pixel_color, irq_flag, busy_res
);
    import sbe_pkg::*;

    localparam int MEM_DEPTH = SPRITE_BANKS * 65536;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam logic [3:0] BANKS = 4'(SPRITE_BANKS);

    // bank number folded into the populated banks (repeated subtract, narrow)
    function automatic logic [2:0] bank_wrap(input logic [2:0] b);
        logic [3:0] v;
        v = {1'b0, b};
        for (int i = 0; i < 8; i++) begin
            if (v >= BANKS) begin
                v = v - BANKS;
            end
        end
        return v[2:0];
    endfunction

    // input field unpacking
    logic [2:0]  in_param_idx;
    logic [7:0]  in_param_value;
    logic [18:0] in_sprite_addr;
    logic [7:0]  in_sprite_data;

    assign in_param_idx   = s_axis_tdata[2:0];
    assign in_param_value = s_axis_tdata[10:3];
    assign in_sprite_addr = s_axis_tdata[29:11];
    assign in_sprite_data = s_axis_tdata[37:30];

    // configuration registers
    logic       r_carry_full, r_fill_mode, r_copy_enable, r_write_zero;
    logic [2:0] r_bank;
    logic       r_frame_page, r_clip_x, r_clip_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry_full  <= 1'b0;
            r_fill_mode   <= 1'b0;
            r_copy_enable <= 1'b0;
            r_write_zero  <= 1'b0;
            r_bank        <= 3'd0;
            r_frame_page  <= 1'b0;
            r_clip_x      <= 1'b0;
            r_clip_y      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CARRY_FULL:  r_carry_full  <= i_cfg_data[0];
                CFG_FILL_MODE:   r_fill_mode   <= i_cfg_data[0];
                CFG_COPY_ENABLE: r_copy_enable <= i_cfg_data[0];
                CFG_WRITE_ZERO:  r_write_zero  <= i_cfg_data[0];
                CFG_SPRITE_BANK: r_bank        <= bank_wrap(i_cfg_data); // kept pre-folded
                CFG_FRAME_PAGE:  r_frame_page  <= i_cfg_data[0];
                CFG_CLIP_X:      r_clip_x      <= i_cfg_data[0];
                CFG_CLIP_Y:      r_clip_y      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // pipeline control
    logic r_p_valid;
    logic r_o_valid;
    logic w_p_adv;
    logic w_in_acc;

    assign w_p_adv       = r_p_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_p_valid || w_p_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // sequencer: counters and parameter registers, updated per accepted request
    t_tick_info w_info;

    sbe_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_in_acc),
        .i_opcode      (s_axis_tuser),
        .i_param_idx   (in_param_idx),
        .i_param_value (in_param_value),
        .i_carry_full  (r_carry_full),
        .o_info        (w_info)
    );

    // sprite ram: writes from sprite requests, reads at the source position
    logic [18:0]       w_rd_full;
    logic [MEM_AW-1:0] w_raddr, w_waddr;
    logic              w_we;
    logic [7:0]        w_ram_q;

    assign w_rd_full = {r_bank, w_info.gy[7], w_info.gx[7], w_info.gy[6:0], w_info.gx[6:0]};
    assign w_raddr   = MEM_AW'(w_rd_full);
    assign w_waddr   = MEM_AW'({bank_wrap(in_sprite_addr[18:16]), in_sprite_addr[15:0]});
    assign w_we      = w_in_acc && (s_axis_tuser == OP_SPRITE_WR);

    sbe_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_sprite_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (in_sprite_data),
        .i_re    (w_in_acc),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    // fetch stage: holds sequencer status while the ram read completes
    t_tick_info r_p_info;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_p_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_p_info <= w_info;
        end
    end

    // color select and write gating
    logic [7:0] w_color;
    logic       w_write;

    assign w_color = r_fill_mode ? r_p_info.fill_color : w_ram_q;
    assign w_write = r_p_info.tick && r_p_info.run && r_copy_enable
                     && (r_write_zero || w_color != 8'd0)
                     && !(r_p_info.dest_x[7] && r_clip_x)
                     && !(r_p_info.dest_y[7] && r_clip_y);

    // output register
    logic        r_o_write, r_o_irq, r_o_busy;
    logic [14:0] r_o_addr;
    logic [7:0]  r_o_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (!r_o_valid || m_axis_tready) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_adv) begin
            r_o_write <= w_write;
            r_o_addr  <= w_write ? {r_frame_page, r_p_info.dest_y[6:0], r_p_info.dest_x[6:0]}
                                 : 15'd0;
            r_o_color <= w_write ? w_color : 8'd0;
            r_o_irq   <= r_p_info.irq;
            r_o_busy  <= r_p_info.run;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_write;
    assign m_axis_tdata  = {7'd0, r_o_busy, r_o_irq, r_o_color, r_o_addr};

    // a pixel write only comes from a running copy
    a_write_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[24])
        else $error("pixel write while not busy");

    // results without a write carry zero address and color
    a_nowrite_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[22:0] == 23'd0))
        else $error("non-write result with payload");

    // an accepted request always lands in the fetch stage
    a_acc_fetch : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_p_valid)
        else $error("accepted request lost");

    // a stalled fetch stage blocks intake, so the ram read data is never overrun
    a_fetch_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && !w_p_adv) |-> !s_axis_tready)
        else $error("ram read overran stalled fetch stage");

endmodule

// File: src/sbe_ram.sv
// sbe_ram: generic single-write, single-read ram with registered read data
// no dependencies
module sbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/sbe_seq.sv
// sbe_seq: parameter registers and the four-phase counter sequencer
// depends on sbe_pkg
module sbe_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [1:0]          i_opcode,
    input  logic [2:0]          i_param_idx,
    input  logic [7:0]          i_param_value,
    input  logic                i_carry_full,
    output sbe_pkg::t_tick_info o_info
);
    import sbe_pkg::*;

    logic [7:0] r_param [PARAM_COUNT];
    logic [7:0] n_param [PARAM_COUNT];
    logic [6:0] r_wc, n_wc, r_hc, n_hc;
    logic [7:0] r_dx, n_dx, r_dy, n_dy, r_sx, n_sx, r_sy, n_sy;
    logic       r_running, n_running, r_init, n_init;
    logic       r_trigger, n_trigger, r_irq, n_irq;

    logic [7:0] wparam, hparam;

    assign wparam = r_param[P_WIDTH];
    assign hparam = r_param[P_HEIGHT];

    always_comb begin
        logic [6:0] w0;
        n_param   = r_param;
        n_wc      = r_wc;
        n_hc      = r_hc;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_sx      = r_sx;
        n_sy      = r_sy;
        n_running = r_running;
        n_init    = r_init;
        n_trigger = r_trigger;
        n_irq     = r_irq;
        w0        = r_wc;
        unique case (i_opcode)
            OP_PARAM: begin
                if (i_param_idx == P_TRIGGER) begin
                    n_trigger = i_param_value[0];
                    n_irq     = 1'b0;
                end else begin
                    n_param[i_param_idx] = i_param_value;
                end
            end
            OP_TICK: begin
                // phase 0: width count
                if (r_running) begin
                    w0 = r_wc - 7'd1;
                end
                if (r_init) begin
                    w0 = wparam[6:0];
                end
                // phase 1: position counters, row step
                if (r_running) begin
                    n_dx = r_dx + 8'd1;
                    n_sx = src_inc(r_sx, i_carry_full);
                    if (w0 == 7'd0) begin
                        n_dy = r_dy + 8'd1;
                        n_sy = src_inc(r_sy, i_carry_full);
                        n_hc = r_hc - 7'd1;
                    end
                end
                if (w0 == 7'd0 || r_init) begin
                    n_dx = r_param[P_DX];
                    n_sx = r_param[P_SX];
                end
                if (r_init) begin
                    n_dy = r_param[P_DY];
                    n_sy = r_param[P_SY];
                    n_hc = hparam[6:0];
                end
                if (n_hc == 7'd0) begin
                    n_running = 1'b0;
                    n_irq     = 1'b1;
                end
                // phase 2: start and width reload
                n_running = n_running || r_init;
                n_wc      = (w0 == 7'd0) ? wparam[6:0] : w0;
                // phase 3: trigger moves to init
                n_init    = r_trigger;
                n_trigger = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_info.tick       = (i_opcode == OP_TICK);
        o_info.run        = n_running;
        o_info.irq        = n_irq;
        o_info.dest_x     = n_dx;
        o_info.dest_y     = n_dy;
        o_info.gx         = ((wparam & MSB_MASK) != 8'd0) ? ~n_sx : n_sx;
        o_info.gy         = ((hparam & MSB_MASK) != 8'd0) ? ~n_sy : n_sy;
        o_info.fill_color = ~r_param[P_COLOR];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PARAM_COUNT; i++) begin
                r_param[i] <= 8'd0;
            end
            r_wc      <= 7'd0;
            r_hc      <= 7'd0;
            r_dx      <= 8'd0;
            r_dy      <= 8'd0;
            r_sx      <= 8'd0;
            r_sy      <= 8'd0;
            r_running <= 1'b0;
            r_init    <= 1'b0;
            r_trigger <= 1'b0;
            r_irq     <= 1'b0;
        end else if (i_en) begin
            r_param   <= n_param;
            r_wc      <= n_wc;
            r_hc      <= n_hc;
            r_dx      <= n_dx;
            r_dy      <= n_dy;
            r_sx      <= n_sx;
            r_sy      <= n_sy;
            r_running <= n_running;
            r_init    <= n_init;
            r_trigger <= n_trigger;
            r_irq     <= n_irq;
        end
    end

endmodule
